// ----- sv/ttur_pkg.sv -----
// Shared types and constants for the tick timer and UART frame receiver.
`default_nettype none

package ttur_pkg;

   // Frame buffer size
   localparam int BUFFER_BYTES = 60;

   // Configuration register indexes
   localparam logic [2:0] REG_RUN_ENABLE        = 3'd0;
   localparam logic [2:0] REG_TICKS_PER_SECOND  = 3'd1;
   localparam logic [2:0] REG_OFF_SECONDS       = 3'd2;
   localparam logic [2:0] REG_KEY_SCAN_TICKS    = 3'd3;
   localparam logic [2:0] REG_REFRESH_TICKS     = 3'd4;
   localparam logic [2:0] REG_POLL_TICKS        = 3'd5;
   localparam logic [2:0] REG_GAP_TICKS         = 3'd6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Register reset values
   localparam logic [15:0] RST_TICKS_PER_SECOND  = 16'd1000;
   localparam logic [7:0]  RST_OFF_SECONDS       = 8'd180;
   localparam logic [15:0] RST_KEY_SCAN_TICKS    = 16'd40;
   localparam logic [15:0] RST_REFRESH_TICKS     = 16'd400;
   localparam logic [15:0] RST_POLL_TICKS        = 16'd1000;
   localparam logic [7:0]  RST_GAP_TICKS         = 8'h0A;

   // Event kinds
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_BYTE = 1'b1;

   // Frame layout
   localparam logic [7:0] START_MARK  = 8'h55;
   localparam logic [7:0] TAIL_MARK   = 8'hAA;
   localparam logic [7:0] TYPE_LONG   = 8'hB1;
   localparam logic [7:0] TYPE_MID    = 8'hB2;
   localparam logic [7:0] TYPE_SHORT_LO = 8'hB3;
   localparam logic [7:0] TYPE_SHORT_HI = 8'hB6;
   localparam logic [7:0] TYPE_SHORT_BASE = 8'hB0;
   localparam int LEN_LONG  = 54;
   localparam int LEN_MID   = 21;
   localparam int LEN_SHORT = 6;
   localparam int POS_TYPE       = 1;
   localparam int POS_TAIL_SHORT = 5;
   localparam int POS_TAIL_MID   = 20;
   localparam int POS_TAIL_LONG  = 53;

   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_LONG  = 3'd1;
   localparam logic [2:0] KIND_MID   = 3'd2;

   // Per-request status, minus the buffer fields
   typedef struct packed {
      logic       key_scan_pulse;
      logic       refresh_pulse;
      logic       blink_phase;
      logic       poll_pulse;
      logic       auto_off;
      logic       beep_done;
      logic [2:0] frame_kind;
      logic       receiver_restart;
   } result_type;

endpackage

`default_nettype wire

// ----- sv/ttur_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ttur_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 60
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read-first: a same-cycle write is not visible on this read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- sv/tick_timers_and_uart_frame_receiver.sv -----
// Top level: tick prescalers, beep countdown and UART idle-gap frame receiver.
// Each request on req_* is a timer tick (req_func 0) or one received UART byte
// (req_func 1), together with the release, key activity, beep load, poll enable
// and buffer read index of that request. Every request gives exactly one
// response on rsp_*: this tick's pulses, the frame kind or receiver restart when
// the gap counter expired, the held byte count and the buffer byte at
// req_read_index as it stands after the request.
// Throughput: one request per cycle while rsp_ready is high. A response passes from
// the frame buffer RAM's registered read in the read stage to the response register
// before rsp_valid rises.
// csr_* writes one configuration register per cycle; write only while idle.
// Reset clears all counters, flags and the valid bit of every buffer entry, so
// the buffer reads as zero until written; registers return to their defaults.
// When rsp_ready is low the response register holds, one more request is kept
// in the read stage, and req_ready drops once both are full.
`default_nettype none

module tick_timers_and_uart_frame_receiver (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   // configuration
   input  wire logic                                           csr_we,
   input  wire logic [ttur_pkg::CSR_INDEX_W-1:0]               csr_index,
   input  wire logic [ttur_pkg::CSR_DATA_W-1:0]                csr_wdata,
   // request channel
   input  wire logic                                           req_valid,
   output      logic                                           req_ready,
   input  wire logic                                           req_func,
   input  wire logic [7:0]                                     req_rx_byte,
   input  wire logic                                           req_frame_release,
   input  wire logic                                           req_key_activity,
   input  wire logic [15:0]                                    req_beep_start,
   input  wire logic                                           req_poll_enable,
   input  wire logic [$clog2(ttur_pkg::BUFFER_BYTES)-1:0]      req_read_index,
   // response channel
   output      logic                                           rsp_valid,
   input  wire logic                                           rsp_ready,
   output      logic                                           rsp_key_scan_pulse,
   output      logic                                           rsp_refresh_pulse,
   output      logic                                           rsp_blink_phase,
   output      logic                                           rsp_poll_pulse,
   output      logic                                           rsp_auto_off,
   output      logic                                           rsp_beep_done,
   output      logic [2:0]                                     rsp_frame_kind,
   output      logic                                           rsp_receiver_restart,
   output      logic [$clog2(ttur_pkg::BUFFER_BYTES+1)-1:0]    rsp_byte_count,
   output      logic [7:0]                                     rsp_read_data
);

   localparam int IDX_W = $clog2(ttur_pkg::BUFFER_BYTES);
   localparam int CNT_W = $clog2(ttur_pkg::BUFFER_BYTES + 1);

   // configuration registers
   logic        run_enable_ff;
   logic [15:0] ticks_per_second_ff;
   logic [7:0]  off_seconds_ff;
   logic [15:0] key_scan_ticks_ff;
   logic [15:0] refresh_ticks_ff;
   logic [15:0] poll_ticks_ff;
   logic [7:0]  gap_ticks_ff;

   // timer and receiver state
   logic [15:0]      second_count_ff, second_count_in;
   logic [7:0]       idle_seconds_ff, idle_seconds_in;
   logic [15:0]      scan_count_ff, scan_count_in;
   logic [15:0]      refresh_count_ff, refresh_count_in;
   logic             blink_bit_ff, blink_bit_in;
   logic [15:0]      poll_count_ff, poll_count_in;
   logic [15:0]      beep_count_ff, beep_count_in;
   logic [7:0]       gap_count_ff, gap_count_in;
   logic [CNT_W-1:0] held_bytes_ff, held_bytes_in;
   logic             frame_pending_ff, frame_pending_in;

   // copies of the buffer bytes the classifier looks at
   logic [7:0] byte_start_ff, byte_type_ff, tail_short_ff, tail_mid_ff, tail_long_ff;
   logic [ttur_pkg::BUFFER_BYTES-1:0] entry_valid_ff;

   // step logic
   logic                accept;
   logic [CNT_W-1:0]    held_rel;
   logic                pending_rel;
   logic [15:0]         second_inc;
   logic [7:0]          idle_inc;
   logic [7:0]          start_after;
   logic                buf_we;
   logic [IDX_W-1:0]    buf_waddr;
   ttur_pkg::result_type step_res;

   // read stage
   logic                 s1_valid_ff;
   ttur_pkg::result_type s1_res_ff;
   logic [CNT_W-1:0]     s1_count_ff;
   logic                 s1_hit_ff;
   logic                 s1_use_ram_ff;
   logic [7:0]           s1_hit_data_ff;
   logic                 s1_advance;
   logic [7:0]           s1_read_data;
   logic [7:0]           ram_rdata;
   logic                 ridx_ok;

   // response register
   logic                 out_valid_ff;
   ttur_pkg::result_type out_res_ff;
   logic [CNT_W-1:0]     out_count_ff;
   logic [7:0]           out_data_ff;

   assign accept     = req_valid && req_ready;
   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         run_enable_ff        <= 1'b0;
         ticks_per_second_ff  <= ttur_pkg::RST_TICKS_PER_SECOND;
         off_seconds_ff       <= ttur_pkg::RST_OFF_SECONDS;
         key_scan_ticks_ff    <= ttur_pkg::RST_KEY_SCAN_TICKS;
         refresh_ticks_ff     <= ttur_pkg::RST_REFRESH_TICKS;
         poll_ticks_ff        <= ttur_pkg::RST_POLL_TICKS;
         gap_ticks_ff         <= ttur_pkg::RST_GAP_TICKS;
      end else if (csr_we) begin
         unique case (csr_index)
            ttur_pkg::REG_RUN_ENABLE:        run_enable_ff        <= csr_wdata[0];
            ttur_pkg::REG_TICKS_PER_SECOND:  ticks_per_second_ff  <= csr_wdata;
            ttur_pkg::REG_OFF_SECONDS:       off_seconds_ff       <= csr_wdata[7:0];
            ttur_pkg::REG_KEY_SCAN_TICKS:    key_scan_ticks_ff    <= csr_wdata;
            ttur_pkg::REG_REFRESH_TICKS:     refresh_ticks_ff     <= csr_wdata;
            ttur_pkg::REG_POLL_TICKS:        poll_ticks_ff        <= csr_wdata;
            ttur_pkg::REG_GAP_TICKS:         gap_ticks_ff         <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ---------------- step ----------------
   assign held_rel    = req_frame_release ? '0 : held_bytes_ff;
   assign pending_rel = req_frame_release ? 1'b0 : frame_pending_ff;
   assign buf_waddr   = held_rel[IDX_W-1:0];
   assign second_inc  = second_count_ff + 16'd1;
   assign idle_inc    = (req_key_activity ? 8'd0 : idle_seconds_ff) + 8'd1;
   // slot 0 as it stands once this byte is stored
   assign start_after = (held_rel == '0) ? req_rx_byte : byte_start_ff;

   always_comb begin
      second_count_in  = second_count_ff;
      idle_seconds_in  = req_key_activity ? 8'd0 : idle_seconds_ff;
      scan_count_in    = scan_count_ff;
      refresh_count_in = refresh_count_ff;
      blink_bit_in     = blink_bit_ff;
      poll_count_in    = poll_count_ff;
      beep_count_in    = (req_beep_start != 16'd0) ? req_beep_start : beep_count_ff;
      gap_count_in     = gap_count_ff;
      held_bytes_in    = held_rel;
      frame_pending_in = pending_rel;
      buf_we           = 1'b0;
      step_res         = '0;

      if (req_func == ttur_pkg::FUNC_BYTE) begin
         gap_count_in = gap_ticks_ff;
         if (held_rel < CNT_W'(ttur_pkg::BUFFER_BYTES) && !pending_rel) begin
            buf_we = 1'b1;
            if (start_after == ttur_pkg::START_MARK) begin
               held_bytes_in = held_rel + CNT_W'(1);
            end
         end
      end else begin
         if (run_enable_ff) begin
            second_count_in = second_inc;
            if (second_inc > ticks_per_second_ff) begin
               second_count_in = 16'd0;
               idle_seconds_in = idle_inc;
               if (idle_inc >= off_seconds_ff) begin
                  idle_seconds_in   = 8'd0;
                  step_res.auto_off = 1'b1;
               end
            end
            scan_count_in = scan_count_ff + 16'd1;
            if (scan_count_in >= key_scan_ticks_ff) begin
               scan_count_in           = 16'd0;
               step_res.key_scan_pulse = 1'b1;
            end
            refresh_count_in = refresh_count_ff + 16'd1;
            if (refresh_count_in >= refresh_ticks_ff) begin
               refresh_count_in       = 16'd0;
               blink_bit_in           = !blink_bit_ff;
               step_res.refresh_pulse = 1'b1;
            end
            if (req_poll_enable) begin
               poll_count_in = poll_count_ff + 16'd1;
               if (poll_count_in >= poll_ticks_ff) begin
                  poll_count_in       = 16'd0;
                  step_res.poll_pulse = 1'b1;
               end
            end
            if (beep_count_in != 16'd0) begin
               beep_count_in      = beep_count_in - 16'd1;
               step_res.beep_done = (beep_count_in == 16'd0);
            end
         end
         if (gap_count_ff != 8'd0) begin
            gap_count_in = gap_count_ff - 8'd1;
            if (gap_count_in == 8'd0) begin
               // frame end: classify from the captured header and tail bytes
               priority if (held_rel == CNT_W'(ttur_pkg::LEN_LONG)
                            && byte_type_ff == ttur_pkg::TYPE_LONG
                            && tail_long_ff == ttur_pkg::TAIL_MARK) begin
                  step_res.frame_kind = ttur_pkg::KIND_LONG;
               end else if (held_rel == CNT_W'(ttur_pkg::LEN_MID)
                            && byte_type_ff == ttur_pkg::TYPE_MID
                            && tail_mid_ff == ttur_pkg::TAIL_MARK) begin
                  step_res.frame_kind = ttur_pkg::KIND_MID;
               end else if (held_rel == CNT_W'(ttur_pkg::LEN_SHORT)
                            && tail_short_ff == ttur_pkg::TAIL_MARK
                            && byte_type_ff >= ttur_pkg::TYPE_SHORT_LO
                            && byte_type_ff <= ttur_pkg::TYPE_SHORT_HI) begin
                  step_res.frame_kind = 3'(byte_type_ff - ttur_pkg::TYPE_SHORT_BASE);
               end else begin
                  step_res.frame_kind = ttur_pkg::KIND_NONE;
               end
               if (step_res.frame_kind != ttur_pkg::KIND_NONE) begin
                  frame_pending_in = 1'b1;
               end else begin
                  held_bytes_in             = '0;
                  step_res.receiver_restart = 1'b1;
               end
            end
         end
      end
      step_res.blink_phase = blink_bit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_count_ff  <= '0;
         idle_seconds_ff  <= '0;
         scan_count_ff    <= '0;
         refresh_count_ff <= '0;
         blink_bit_ff     <= 1'b0;
         poll_count_ff    <= '0;
         beep_count_ff    <= '0;
         gap_count_ff     <= '0;
         held_bytes_ff    <= '0;
         frame_pending_ff <= 1'b0;
         byte_start_ff    <= '0;
         byte_type_ff     <= '0;
         tail_short_ff    <= '0;
         tail_mid_ff      <= '0;
         tail_long_ff     <= '0;
         entry_valid_ff   <= '0;
      end else if (accept) begin
         second_count_ff  <= second_count_in;
         idle_seconds_ff  <= idle_seconds_in;
         scan_count_ff    <= scan_count_in;
         refresh_count_ff <= refresh_count_in;
         blink_bit_ff     <= blink_bit_in;
         poll_count_ff    <= poll_count_in;
         beep_count_ff    <= beep_count_in;
         gap_count_ff     <= gap_count_in;
         held_bytes_ff    <= held_bytes_in;
         frame_pending_ff <= frame_pending_in;
         if (buf_we) begin
            entry_valid_ff[buf_waddr] <= 1'b1;
            if (buf_waddr == '0) begin
               byte_start_ff <= req_rx_byte;
            end
            if (buf_waddr == IDX_W'(ttur_pkg::POS_TYPE)) begin
               byte_type_ff <= req_rx_byte;
            end
            if (buf_waddr == IDX_W'(ttur_pkg::POS_TAIL_SHORT)) begin
               tail_short_ff <= req_rx_byte;
            end
            if (buf_waddr == IDX_W'(ttur_pkg::POS_TAIL_MID)) begin
               tail_mid_ff <= req_rx_byte;
            end
            if (buf_waddr == IDX_W'(ttur_pkg::POS_TAIL_LONG)) begin
               tail_long_ff <= req_rx_byte;
            end
         end
      end
   end

   // ---------------- frame buffer ----------------
   ttur_ram #(
      .WIDTH (8),
      .DEPTH (ttur_pkg::BUFFER_BYTES)
   ) u_frame_ram (
      .clock (clock),
      .we    (accept && buf_we),
      .waddr (buf_waddr),
      .wdata (req_rx_byte),
      .re    (accept),
      .raddr (req_read_index),
      .rdata (ram_rdata)
   );

   assign ridx_ok = ({1'b0, req_read_index} < (IDX_W + 1)'(ttur_pkg::BUFFER_BYTES));

   // read stage: RAM data is read-first, so a write to the same entry forwards
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff      <= step_res;
         s1_count_ff    <= held_bytes_in;
         s1_hit_ff      <= ridx_ok && buf_we && (buf_waddr == req_read_index);
         s1_use_ram_ff  <= ridx_ok && entry_valid_ff[req_read_index];
         s1_hit_data_ff <= req_rx_byte;
      end
   end

   always_comb begin
      priority if (s1_hit_ff) begin
         s1_read_data = s1_hit_data_ff;
      end else if (s1_use_ram_ff) begin
         s1_read_data = ram_rdata;
      end else begin
         s1_read_data = 8'd0;
      end
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_res_ff   <= s1_res_ff;
         out_count_ff <= s1_count_ff;
         out_data_ff  <= s1_read_data;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_key_scan_pulse   = out_res_ff.key_scan_pulse;
   assign rsp_refresh_pulse    = out_res_ff.refresh_pulse;
   assign rsp_blink_phase      = out_res_ff.blink_phase;
   assign rsp_poll_pulse       = out_res_ff.poll_pulse;
   assign rsp_auto_off         = out_res_ff.auto_off;
   assign rsp_beep_done        = out_res_ff.beep_done;
   assign rsp_frame_kind       = out_res_ff.frame_kind;
   assign rsp_receiver_restart = out_res_ff.receiver_restart;
   assign rsp_byte_count       = out_count_ff;
   assign rsp_read_data        = out_data_ff;

   // ---------------- assertions ----------------
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      held_bytes_ff <= CNT_W'(ttur_pkg::BUFFER_BYTES))
      else $error("held byte count beyond buffer size");

   a_kind_xor_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_frame_kind != ttur_pkg::KIND_NONE && rsp_receiver_restart))
      else $error("frame accepted and restarted on the same request");

   a_byte_no_pulse: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == ttur_pkg::FUNC_BYTE) |=>
         (!s1_res_ff.key_scan_pulse && !s1_res_ff.auto_off
          && s1_res_ff.frame_kind == ttur_pkg::KIND_NONE))
      else $error("byte request produced a timer or frame result");

   a_pending_stable_on_byte: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == ttur_pkg::FUNC_BYTE && !req_frame_release) |=>
         (frame_pending_ff == $past(frame_pending_ff)))
      else $error("frame pending changed on a byte request");

endmodule

`default_nettype wire

// ----- bench/ttur_checker.sv -----
// Checker for the tick timer and UART frame receiver: predicts each response and compares it.
`timescale 1ns / 1ps
`default_nettype none

module ttur_checker (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         csr_we,
   input  wire logic [ttur_pkg::CSR_INDEX_W-1:0]             csr_index,
   input  wire logic [ttur_pkg::CSR_DATA_W-1:0]              csr_wdata,
   input  wire logic                                         req_valid,
   input  wire logic                                         req_ready,
   input  wire logic                                         req_func,
   input  wire logic [7:0]                                   req_rx_byte,
   input  wire logic                                         req_frame_release,
   input  wire logic                                         req_key_activity,
   input  wire logic [15:0]                                  req_beep_start,
   input  wire logic                                         req_poll_enable,
   input  wire logic [$clog2(ttur_pkg::BUFFER_BYTES)-1:0]    req_read_index,
   input  wire logic                                         rsp_valid,
   input  wire logic                                         rsp_ready,
   input  wire logic                                         rsp_key_scan_pulse,
   input  wire logic                                         rsp_refresh_pulse,
   input  wire logic                                         rsp_blink_phase,
   input  wire logic                                         rsp_poll_pulse,
   input  wire logic                                         rsp_auto_off,
   input  wire logic                                         rsp_beep_done,
   input  wire logic [2:0]                                   rsp_frame_kind,
   input  wire logic                                         rsp_receiver_restart,
   input  wire logic [$clog2(ttur_pkg::BUFFER_BYTES+1)-1:0]  rsp_byte_count,
   input  wire logic [7:0]                                   rsp_read_data,
   output int                                                mismatch_count,
   output int                                                status_backlog
);

   localparam int BUF_BYTES = ttur_pkg::BUFFER_BYTES;
   localparam int IDX_W = $clog2(BUF_BYTES);
   localparam int CNT_W = $clog2(BUF_BYTES + 1);

   typedef struct packed {
      ttur_pkg::result_type flags;
      logic [CNT_W-1:0]     count;
      logic [7:0]           data;
   } rsp_status_type;

   // configuration copy
   logic        run_en;
   logic [15:0] sec_limit;
   logic [7:0]  off_limit;
   logic [15:0] scan_limit;
   logic [15:0] refresh_limit;
   logic [15:0] poll_limit;
   logic [7:0]  gap_limit;

   // timer and receiver state
   logic [15:0]      sec_cnt;
   logic [7:0]       idle_sec;
   logic [15:0]      scan_cnt;
   logic [15:0]      refresh_cnt;
   logic             blink;
   logic [15:0]      poll_cnt;
   logic [15:0]      beep_cnt;
   logic [7:0]       gap_cnt;
   logic [CNT_W-1:0] held;
   logic             frame_held;
   logic [7:0]       frame_buf [BUF_BYTES];

   rsp_status_type expected_status [$];

   initial begin
      mismatch_count = 0;
      status_backlog = 0;
   end

   function automatic logic [2:0] frame_kind_now();
      logic [7:0] ftype;
      ftype = frame_buf[ttur_pkg::POS_TYPE];
      if (held == CNT_W'(ttur_pkg::LEN_LONG) && ftype == ttur_pkg::TYPE_LONG &&
          frame_buf[ttur_pkg::POS_TAIL_LONG] == ttur_pkg::TAIL_MARK)
         return ttur_pkg::KIND_LONG;
      if (held == CNT_W'(ttur_pkg::LEN_MID) && ftype == ttur_pkg::TYPE_MID &&
          frame_buf[ttur_pkg::POS_TAIL_MID] == ttur_pkg::TAIL_MARK)
         return ttur_pkg::KIND_MID;
      if (held == CNT_W'(ttur_pkg::LEN_SHORT) &&
          frame_buf[ttur_pkg::POS_TAIL_SHORT] == ttur_pkg::TAIL_MARK &&
          ftype >= ttur_pkg::TYPE_SHORT_LO && ftype <= ttur_pkg::TYPE_SHORT_HI)
         return 3'(ftype - ttur_pkg::TYPE_SHORT_BASE);
      return ttur_pkg::KIND_NONE;
   endfunction

   function automatic rsp_status_type step_receiver(input logic func, input logic [7:0] rx,
                                                    input logic drop, input logic key,
                                                    input logic [15:0] beep, input logic poll,
                                                    input logic [IDX_W-1:0] ridx);
      rsp_status_type s;
      s = '0;
      if (drop) begin
         frame_held = 1'b0;
         held = '0;
      end
      if (key)
         idle_sec = '0;
      if (beep != 16'd0)
         beep_cnt = beep;

      if (func == ttur_pkg::FUNC_BYTE) begin
         gap_cnt = gap_limit;
         if (held < CNT_W'(BUF_BYTES) && !frame_held) begin
            frame_buf[held] = rx;
            // count only runs once the start mark sits in slot 0
            if (frame_buf[0] == ttur_pkg::START_MARK)
               held = held + CNT_W'(1);
         end
      end else begin
         if (run_en) begin
            sec_cnt = sec_cnt + 16'd1;
            if (sec_cnt > sec_limit) begin
               sec_cnt = '0;
               idle_sec = idle_sec + 8'd1;
               if (idle_sec >= off_limit) begin
                  idle_sec = '0;
                  s.flags.auto_off = 1'b1;
               end
            end
            scan_cnt = scan_cnt + 16'd1;
            if (scan_cnt >= scan_limit) begin
               scan_cnt = '0;
               s.flags.key_scan_pulse = 1'b1;
            end
            refresh_cnt = refresh_cnt + 16'd1;
            if (refresh_cnt >= refresh_limit) begin
               refresh_cnt = '0;
               blink = ~blink;
               s.flags.refresh_pulse = 1'b1;
            end
            if (poll) begin
               poll_cnt = poll_cnt + 16'd1;
               if (poll_cnt >= poll_limit) begin
                  poll_cnt = '0;
                  s.flags.poll_pulse = 1'b1;
               end
            end
            if (beep_cnt != 16'd0) begin
               beep_cnt = beep_cnt - 16'd1;
               if (beep_cnt == 16'd0)
                  s.flags.beep_done = 1'b1;
            end
         end
         if (gap_cnt != 8'd0) begin
            gap_cnt = gap_cnt - 8'd1;
            if (gap_cnt == 8'd0) begin
               s.flags.frame_kind = frame_kind_now();
               if (s.flags.frame_kind != ttur_pkg::KIND_NONE) begin
                  frame_held = 1'b1;
               end else begin
                  held = '0;
                  s.flags.receiver_restart = 1'b1;
               end
            end
         end
      end

      s.flags.blink_phase = blink;
      s.count = held;
      s.data = ({1'b0, ridx} < (IDX_W + 1)'(BUF_BYTES)) ? frame_buf[ridx] : 8'h00;
      return s;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_status_type want;
      if (reset) begin
         run_en = 1'b0;
         sec_limit = ttur_pkg::RST_TICKS_PER_SECOND;
         off_limit = ttur_pkg::RST_OFF_SECONDS;
         scan_limit = ttur_pkg::RST_KEY_SCAN_TICKS;
         refresh_limit = ttur_pkg::RST_REFRESH_TICKS;
         poll_limit = ttur_pkg::RST_POLL_TICKS;
         gap_limit = ttur_pkg::RST_GAP_TICKS;
         sec_cnt = '0;
         idle_sec = '0;
         scan_cnt = '0;
         refresh_cnt = '0;
         blink = 1'b0;
         poll_cnt = '0;
         beep_cnt = '0;
         gap_cnt = '0;
         held = '0;
         frame_held = 1'b0;
         foreach (frame_buf[i])
            frame_buf[i] = 8'h00;
         expected_status.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               ttur_pkg::REG_RUN_ENABLE:       run_en = csr_wdata[0];
               ttur_pkg::REG_TICKS_PER_SECOND: sec_limit = csr_wdata;
               ttur_pkg::REG_OFF_SECONDS:      off_limit = csr_wdata[7:0];
               ttur_pkg::REG_KEY_SCAN_TICKS:   scan_limit = csr_wdata;
               ttur_pkg::REG_REFRESH_TICKS:    refresh_limit = csr_wdata;
               ttur_pkg::REG_POLL_TICKS:       poll_limit = csr_wdata;
               ttur_pkg::REG_GAP_TICKS:        gap_limit = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_status.push_back(step_receiver(req_func, req_rx_byte, req_frame_release,
                                                    req_key_activity, req_beep_start,
                                                    req_poll_enable, req_read_index));
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               mismatch_count++;
               $display("%0t: response with no request waiting: byte_count %0d read_data %0d",
                        $time, rsp_byte_count, rsp_read_data);
            end else begin
               want = expected_status.pop_front();
               check_field("key_scan_pulse", int'(want.flags.key_scan_pulse),
                           int'(rsp_key_scan_pulse));
               check_field("refresh_pulse", int'(want.flags.refresh_pulse),
                           int'(rsp_refresh_pulse));
               check_field("blink_phase", int'(want.flags.blink_phase), int'(rsp_blink_phase));
               check_field("poll_pulse", int'(want.flags.poll_pulse), int'(rsp_poll_pulse));
               check_field("auto_off", int'(want.flags.auto_off), int'(rsp_auto_off));
               check_field("beep_done", int'(want.flags.beep_done), int'(rsp_beep_done));
               check_field("frame_kind", int'(want.flags.frame_kind), int'(rsp_frame_kind));
               check_field("receiver_restart", int'(want.flags.receiver_restart),
                           int'(rsp_receiver_restart));
               check_field("byte_count", int'(want.count), int'(rsp_byte_count));
               check_field("read_data", int'(want.data), int'(rsp_read_data));
            end
         end
      end
      status_backlog <= expected_status.size();
   end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Testbench top: drives ticks, UART bytes and register writes into the frame receiver.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_we = 1'b0;
   logic [ttur_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ttur_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic                             req_func = ttur_pkg::FUNC_TICK;
   logic [7:0]                       req_rx_byte = '0;
   logic                             req_frame_release = 1'b0;
   logic                             req_key_activity = 1'b0;
   logic [15:0]                      req_beep_start = '0;
   logic                             req_poll_enable = 1'b0;
   logic [5:0]                       req_read_index = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_key_scan_pulse;
   logic                             rsp_refresh_pulse;
   logic                             rsp_blink_phase;
   logic                             rsp_poll_pulse;
   logic                             rsp_auto_off;
   logic                             rsp_beep_done;
   logic [2:0]                       rsp_frame_kind;
   logic                             rsp_receiver_restart;
   logic [5:0]                       rsp_byte_count;
   logic [7:0]                       rsp_read_data;

   int   mismatch_count;
   int   status_backlog;
   int   item_total = 0;
   int   gap_now = int'(ttur_pkg::RST_GAP_TICKS);
   logic steady = 1'b0;
   int   stall_left = 0;
   int   roll;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tick_timers_and_uart_frame_receiver dut (
      .clock, .reset,
      .csr_we, .csr_index, .csr_wdata,
      .req_valid, .req_ready, .req_func, .req_rx_byte, .req_frame_release,
      .req_key_activity, .req_beep_start, .req_poll_enable, .req_read_index,
      .rsp_valid, .rsp_ready, .rsp_key_scan_pulse, .rsp_refresh_pulse, .rsp_blink_phase,
      .rsp_poll_pulse, .rsp_auto_off, .rsp_beep_done, .rsp_frame_kind,
      .rsp_receiver_restart, .rsp_byte_count, .rsp_read_data
   );

   ttur_checker u_checker (
      .clock, .reset,
      .csr_we, .csr_index, .csr_wdata,
      .req_valid, .req_ready, .req_func, .req_rx_byte, .req_frame_release,
      .req_key_activity, .req_beep_start, .req_poll_enable, .req_read_index,
      .rsp_valid, .rsp_ready, .rsp_key_scan_pulse, .rsp_refresh_pulse, .rsp_blink_phase,
      .rsp_poll_pulse, .rsp_auto_off, .rsp_beep_done, .rsp_frame_kind,
      .rsp_receiver_restart, .rsp_byte_count, .rsp_read_data,
      .mismatch_count, .status_backlog
   );

   // response back-pressure: mostly short stalls, a few long ones
   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            stall_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else if (roll < 17) begin
            stall_left = $urandom_range(8, 40);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic issue(input logic func, input logic [7:0] rx, input logic drop,
                        input logic key, input logic [15:0] beep, input logic poll,
                        input logic [5:0] ridx);
      int idle;
      int dice;
      idle = 0;
      if (!steady) begin
         dice = $urandom_range(0, 99);
         if (dice >= 92)
            idle = $urandom_range(8, 40);
         else if (dice >= 65)
            idle = $urandom_range(1, 3);
      end
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_rx_byte <= rx;
      req_frame_release <= drop;
      req_key_activity <= key;
      req_beep_start <= beep;
      req_poll_enable <= poll;
      req_read_index <= ridx;
      do @(posedge clock); while (!req_ready);
      item_total++;
   endtask

   task automatic send_event(input logic func, input logic [7:0] rx, input logic drop);
      logic [15:0] beep;
      int          pick;
      pick = $urandom_range(0, 19);
      beep = (pick == 0) ? 16'($urandom_range(1, 30)) :
             (pick == 1) ? 16'($urandom) : 16'd0;
      issue(func, rx, drop, $urandom_range(0, 15) == 0, beep, $urandom_range(0, 7) != 0,
            6'($urandom_range(0, 63)));
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_event(ttur_pkg::FUNC_TICK, 8'($urandom), 1'b0);
   endtask

   task automatic send_frame_bytes(input logic [7:0] data[$]);
      foreach (data[i])
         send_event(ttur_pkg::FUNC_BYTE, data[i], 1'b0);
   endtask

   task automatic write_csr(input logic [ttur_pkg::CSR_INDEX_W-1:0] idx, input int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(value);
      @(posedge clock);
   endtask

   // registers change only with nothing in flight
   task automatic configure(input logic run, input int tps, input int off, input int scan,
                            input int refr, input int poll, input int gap);
      req_valid <= 1'b0;
      @(posedge clock);
      while (status_backlog != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_csr(ttur_pkg::REG_RUN_ENABLE, int'(run));
      write_csr(ttur_pkg::REG_TICKS_PER_SECOND, tps);
      write_csr(ttur_pkg::REG_OFF_SECONDS, off);
      write_csr(ttur_pkg::REG_KEY_SCAN_TICKS, scan);
      write_csr(ttur_pkg::REG_REFRESH_TICKS, refr);
      write_csr(ttur_pkg::REG_POLL_TICKS, poll);
      write_csr(ttur_pkg::REG_GAP_TICKS, gap);
      csr_we <= 1'b0;
      gap_now = gap;
   endtask

   // well-formed frame of a random kind, sometimes damaged, then the idle gap
   task automatic send_random_frame();
      logic [7:0] data[$];
      int         kind;
      int         len;
      int         flaw;
      kind = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
      len = (kind == int'(ttur_pkg::KIND_LONG)) ? ttur_pkg::LEN_LONG :
            (kind == int'(ttur_pkg::KIND_MID)) ? ttur_pkg::LEN_MID : ttur_pkg::LEN_SHORT;
      data.push_back(ttur_pkg::START_MARK);
      data.push_back((kind == int'(ttur_pkg::KIND_LONG)) ? ttur_pkg::TYPE_LONG :
                     (kind == int'(ttur_pkg::KIND_MID)) ? ttur_pkg::TYPE_MID :
                     8'(int'(ttur_pkg::TYPE_SHORT_BASE) + kind));
      repeat (len - 3) data.push_back(8'($urandom));
      data.push_back(ttur_pkg::TAIL_MARK);
      flaw = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 4) : 0;
      case (flaw)
         1: data[ttur_pkg::POS_TYPE] = data[ttur_pkg::POS_TYPE] ^ 8'($urandom_range(1, 255));
         2: data[len-1] = data[len-1] ^ 8'($urandom_range(1, 255));
         3: if ($urandom_range(0, 1) == 0)
               void'(data.pop_back());
            else
               data.push_back(8'($urandom));
         4: data[0] = ttur_pkg::START_MARK ^ 8'($urandom_range(1, 255));
         default: ;
      endcase
      send_frame_bytes(data);
      send_ticks(((gap_now == 0) ? 3 : gap_now) + $urandom_range(0, 2));
      if ($urandom_range(0, 1) == 0)
         send_event(ttur_pkg::FUNC_TICK, 8'($urandom), 1'b1);
   endtask

   initial begin
      logic [7:0] frame_bytes[$];
      int         budget;
      int         phase_start;
      int         pick;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // timers off, default registers: beep load, byte without start mark, read past end
      issue(ttur_pkg::FUNC_TICK, 8'hFF, 1'b0, 1'b1, 16'hFFFF, 1'b1, 6'd63);
      issue(ttur_pkg::FUNC_BYTE, 8'h12, 1'b0, 1'b0, 16'd0, 1'b0, 6'd0);
      issue(ttur_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b0, 16'd0, 1'b1, 6'd60);
      issue(ttur_pkg::FUNC_TICK, 8'h00, 1'b1, 1'b0, 16'd0, 1'b0, 6'd59);

      configure(1'b1, 1, 1, 1, 2, 2, 2);
      // beep of one tick ends on the same tick
      issue(ttur_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b0, 16'd1, 1'b1, 6'd0);
      frame_bytes = {ttur_pkg::START_MARK, 8'hB4, 8'h00, 8'hFF, 8'h80, ttur_pkg::TAIL_MARK};
      send_frame_bytes(frame_bytes);
      send_ticks(3);
      // byte while a frame is held is dropped, but re-arms the gap: kind reported again
      send_event(ttur_pkg::FUNC_BYTE, 8'h33, 1'b0);
      send_ticks(2);
      issue(ttur_pkg::FUNC_TICK, 8'h00, 1'b1, 1'b1, 16'd0, 1'b0, 6'd5);
      frame_bytes = {ttur_pkg::START_MARK, 8'hB7, 8'h01, 8'h02, 8'h03, ttur_pkg::TAIL_MARK};
      send_frame_bytes(frame_bytes);
      send_ticks(2);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: configure(1'b1, 0, 0, 0, 0, 0, 0);
            1: configure(1'b1, 1, 1, 1, 1, 1, 1);
            2: configure(1'b1, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
            3: configure(1'b0, $urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 7),
                         $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(1, 6));
            default:
               configure($urandom_range(0, 7) != 0, $urandom_range(0, 5), $urandom_range(0, 4),
                         $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
                         $urandom_range(1, 6));
         endcase
         steady = (phase == 1 || phase == 5);
         // the long gap of phase 2 makes one frame run past 250 requests
         budget = (phase == 2) ? 200 : 60;
         phase_start = item_total;
         while (item_total - phase_start < budget) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               send_random_frame();
            end else if (pick < 9) begin
               repeat ($urandom_range(1, 8))
                  send_event(1'($urandom_range(0, 1)), 8'($urandom),
                             $urandom_range(0, 7) == 0);
            end else begin
               send_event(ttur_pkg::FUNC_TICK, 8'($urandom), 1'b1);
            end
         end
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      @(posedge clock);
      while (status_backlog != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS tick_timers_and_uart_frame_receiver");
      else
         $display("FAIL tick_timers_and_uart_frame_receiver");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAIL tick_timers_and_uart_frame_receiver");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/ttur_pkg.sv
sv/ttur_ram.sv
sv/tick_timers_and_uart_frame_receiver.sv
bench/ttur_checker.sv
bench/testbench.sv
